### sv/bfh_pkg.sv
// bfh_pkg: shared sizes, operation and status codes, and the cell command and
// control status types for the back/forward history stack; no dependencies
package bfh_pkg;

  localparam int DEPTH     = 32;
  localparam int TAG_WIDTH = 32;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int PORT_TAG_W = 32;
  localparam int PORT_CNT_W = 6;

  localparam logic [OP_W-1:0] OP_VISIT   = 2'd0;
  localparam logic [OP_W-1:0] OP_BACK    = 2'd1;
  localparam logic [OP_W-1:0] OP_FORWARD = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HOME     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_LAST     = 2'd3;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                 insert;
    logic [IDX_W-1:0]     pos;
    logic [TAG_WIDTH-1:0] tag;
  } cell_cmd_t;

  // control to the output stage
  typedef struct packed {
    logic                load;
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    back_cnt;
    logic [CNT_W-1:0]    fwd_cnt;
    logic [IDX_W-1:0]    read_idx;
    logic                back_empty;
  } ctrl_stat_t;

endpackage

### sv/bfh_cell.sv
// bfh_cell: one slot of the history row; takes the new tag or its left
// neighbor's tag on an insert; uses bfh_pkg
module bfh_cell (
  input  logic                          clk,
  input  logic [bfh_pkg::IDX_W-1:0]     cell_idx,
  input  bfh_pkg::cell_cmd_t            cmd,
  input  logic [bfh_pkg::TAG_WIDTH-1:0] left_q,
  output logic [bfh_pkg::TAG_WIDTH-1:0] q
);

  logic [bfh_pkg::TAG_WIDTH-1:0] data_r;
  logic [bfh_pkg::TAG_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (cmd.insert && (cell_idx >= cmd.pos)) begin
      data_nxt = (cell_idx == cmd.pos) ? cmd.tag : left_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

### sv/bfh_ctrl.sv
// bfh_ctrl: stack counts, status decode and the two-step sequencer that
// drives the cell row and the output stage; uses bfh_pkg
module bfh_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bfh_pkg::OP_W-1:0]       in_operation,
  input  logic [bfh_pkg::PORT_TAG_W-1:0] in_entry_tag,
  input  logic                           out_free,
  output bfh_pkg::cell_cmd_t             cmd,
  output bfh_pkg::ctrl_stat_t            stat
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_READ = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic [bfh_pkg::CNT_W-1:0] back_r, back_nxt;
  logic [bfh_pkg::CNT_W-1:0] fwd_r, fwd_nxt;
  logic [bfh_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [bfh_pkg::CNT_W:0] used;
  logic accept;
  logic full;
  logic back_zero;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign used      = {1'b0, back_r} + {1'b0, fwd_r};
  assign full      = (used >= (bfh_pkg::CNT_W+1)'(bfh_pkg::DEPTH));
  assign back_zero = (back_r == '0);

  always_comb begin
    back_nxt   = back_r;
    fwd_nxt    = fwd_r;
    status_nxt = status_r;
    cmd.insert = 1'b0;
    cmd.pos    = back_r[bfh_pkg::IDX_W-1:0];
    cmd.tag    = bfh_pkg::TAG_WIDTH'(in_entry_tag);
    if (accept) begin
      unique case (in_operation)
        bfh_pkg::OP_VISIT: begin
          if (full) begin
            status_nxt = bfh_pkg::ST_OVERFLOW;
          end else begin
            cmd.insert = 1'b1;
            back_nxt   = back_r + 1'b1;
            status_nxt = bfh_pkg::ST_OK;
          end
        end
        bfh_pkg::OP_BACK: begin
          if (back_zero) begin
            status_nxt = bfh_pkg::ST_HOME;
          end else begin
            // the row order does not change, only the cursor moves
            back_nxt   = back_r - 1'b1;
            fwd_nxt    = fwd_r + 1'b1;
            status_nxt = (back_r == bfh_pkg::CNT_W'(1)) ? bfh_pkg::ST_HOME : bfh_pkg::ST_OK;
          end
        end
        bfh_pkg::OP_FORWARD: begin
          if (fwd_r == '0) begin
            status_nxt = back_zero ? bfh_pkg::ST_HOME : bfh_pkg::ST_LAST;
          end else begin
            back_nxt   = back_r + 1'b1;
            fwd_nxt    = fwd_r - 1'b1;
            status_nxt = bfh_pkg::ST_OK;
          end
        end
        default: begin
          status_nxt = back_zero ? bfh_pkg::ST_HOME : bfh_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      back_r   <= '0;
      fwd_r    <= '0;
      status_r <= bfh_pkg::ST_HOME;
    end else begin
      state_r  <= state_nxt;
      back_r   <= back_nxt;
      fwd_r    <= fwd_nxt;
      status_r <= status_nxt;
    end
  end

  logic [bfh_pkg::CNT_W-1:0] back_m1;
  assign back_m1 = back_r - 1'b1;

  assign stat.load       = (state_r == S_READ) && out_free;
  assign stat.status     = status_r;
  assign stat.back_cnt   = back_r;
  assign stat.fwd_cnt    = fwd_r;
  assign stat.read_idx   = back_m1[bfh_pkg::IDX_W-1:0];
  assign stat.back_empty = back_zero;

endmodule

### sv/back_forward_history_stack_top.sv
// back_forward_history_stack_top: back/forward history held in a row of
// cells; instantiates bfh_ctrl and bfh_cell, uses bfh_pkg
//
// sequence: an accepted transaction updates the row and the counts; from the
//   read state the new top is loaded into the output register once that
//   register is free, and no new transaction is taken until then
// reset: synchronous active-low rst_n empties both stacks and the output;
//   cell contents are not cleared and are never read before being written
module back_forward_history_stack_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bfh_pkg::OP_W-1:0]           in_operation,
  input  logic [bfh_pkg::PORT_TAG_W-1:0]     in_entry_tag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bfh_pkg::STATUS_W-1:0]       out_status,
  output logic [bfh_pkg::PORT_TAG_W-1:0]     out_current_tag,
  output logic [bfh_pkg::PORT_CNT_W-1:0]     out_back_count,
  output logic [bfh_pkg::PORT_CNT_W-1:0]     out_forward_count
);

  // the row keeps the whole history in order: back-stack entries from cell 0
  // up, then forward-stack entries with the forward top right after the
  // current entry; back and forward only move the cursor, a visit inserts
  // at the cursor and shifts the later cells one place to the right

  bfh_pkg::cell_cmd_t  cmd;
  bfh_pkg::ctrl_stat_t stat;
  logic                out_free;

  logic [bfh_pkg::TAG_WIDTH-1:0] cell_q [bfh_pkg::DEPTH];

  logic                               out_valid_r, out_valid_nxt;
  logic [bfh_pkg::STATUS_W-1:0]       status_r;
  logic [bfh_pkg::PORT_TAG_W-1:0]     tag_r;
  logic [bfh_pkg::PORT_CNT_W-1:0]     back_cnt_r;
  logic [bfh_pkg::PORT_CNT_W-1:0]     fwd_cnt_r;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  bfh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_entry_tag (in_entry_tag),
    .out_free     (out_free),
    .cmd          (cmd),
    .stat         (stat)
  );

  // row of cells, cell 0 has no left neighbor
  for (genvar i = 0; i < bfh_pkg::DEPTH; i++) begin : g_cell
    logic [bfh_pkg::TAG_WIDTH-1:0] left_q;
    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_rest
      assign left_q = cell_q[i-1];
    end
    bfh_cell u_cell (
      .clk      (clk),
      .cell_idx (bfh_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .left_q   (left_q),
      .q        (cell_q[i])
    );
  end

  // current entry is the cell just below the cursor, zero at home
  logic [bfh_pkg::TAG_WIDTH-1:0] cur_tag;
  assign cur_tag = stat.back_empty ? '0 : cell_q[stat.read_idx];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded once per transaction
  always_ff @(posedge clk) begin
    if (stat.load) begin
      status_r   <= stat.status;
      tag_r      <= bfh_pkg::PORT_TAG_W'(cur_tag);
      back_cnt_r <= bfh_pkg::PORT_CNT_W'(stat.back_cnt);
      fwd_cnt_r  <= bfh_pkg::PORT_CNT_W'(stat.fwd_cnt);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_current_tag   = tag_r;
  assign out_back_count    = back_cnt_r;
  assign out_forward_count = fwd_cnt_r;

endmodule

### sv/bfh_checker.sv
// bfh_checker: port-level checks for back_forward_history_stack_top, with
// its bind statement; uses bfh_pkg
module bfh_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bfh_pkg::STATUS_W-1:0]   out_status,
  input logic [bfh_pkg::PORT_TAG_W-1:0] out_current_tag,
  input logic [bfh_pkg::PORT_CNT_W-1:0] out_back_count,
  input logic [bfh_pkg::PORT_CNT_W-1:0] out_forward_count
);

  logic [bfh_pkg::PORT_CNT_W:0] cnt_sum;
  assign cnt_sum = {1'b0, out_back_count} + {1'b0, out_forward_count};

  // stalled result holds its status, current tag and back count
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_current_tag) && $stable(out_back_count))
    else $error("stalled result changed");

  // an accepted transaction blocks the input for the next cycle
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // at home the back stack is empty and the current tag is zero
  a_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bfh_pkg::ST_HOME |->
      out_back_count == '0 && out_current_tag == '0)
    else $error("home status with back entries");

  // an empty back stack only reports home or overflow
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_back_count == '0 |->
      out_status == bfh_pkg::ST_HOME || out_status == bfh_pkg::ST_OVERFLOW)
    else $error("empty back stack with ok or last status");

  // overflow only when the store is full, and never beyond it
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bfh_pkg::ST_OVERFLOW |->
      cnt_sum == (bfh_pkg::PORT_CNT_W+1)'(bfh_pkg::DEPTH))
    else $error("overflow reported with free slots");

endmodule

bind back_forward_history_stack_top bfh_checker u_bfh_checker (.*);
